// ===== src/lsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and controller/datapath command structs for the
// latency statistics accumulator. No dependencies.
package lsa_pkg;

    localparam int NUM_KINDS      = 4;
    localparam int MEAN_FRAC_BITS = 16;

    localparam int KIND_W     = 2;
    localparam int DUR_W      = 32;
    localparam int COUNT_W    = 32;
    localparam int TOTAL_W    = 64;
    localparam int MEAN_OUT_W = 48;

    // Internal mean word: 32 integer bits plus the fraction.
    localparam int MEAN_W     = DUR_W + MEAN_FRAC_BITS;
    // Divisor is count + 1, one bit wider than the count.
    localparam int DIV_W      = COUNT_W + 1;
    localparam int REM_W      = DIV_W + 1;
    localparam int KIND_IDX_W = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int STEP_W     = $clog2(MEAN_W);

    localparam logic [DUR_W-1:0] RESET_THRESHOLD = DUR_W'(200000);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIVIDE,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic load;
        logic step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic keep;
        logic out_stall;
    } t_dp_stat;

endpackage

// ===== src/lsa_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: event kind and measured duration with valid/ready.
// Depends on lsa_pkg.
interface lsa_in_if;
    logic                        valid;
    logic                        ready;
    logic [lsa_pkg::KIND_W-1:0]  event_kind;
    logic [lsa_pkg::DUR_W-1:0]   duration;

    modport source (output valid, output event_kind, output duration, input ready);
    modport sink   (input valid, input event_kind, input duration, output ready);
endinterface

// ===== src/lsa_out_if.sv =====
`timescale 1ns / 1ps
// Result channel: updated statistics of one kind with valid/ready.
// Depends on lsa_pkg.
interface lsa_out_if;
    logic                            valid;
    logic                            ready;
    logic                            accepted;
    logic [lsa_pkg::COUNT_W-1:0]     sample_count;
    logic [lsa_pkg::DUR_W-1:0]       smallest;
    logic [lsa_pkg::DUR_W-1:0]       largest;
    logic [lsa_pkg::TOTAL_W-1:0]     sum_of_durations;
    logic [lsa_pkg::MEAN_OUT_W-1:0]  mean_value;

    modport source (output valid, output accepted, output sample_count, output smallest,
                    output largest, output sum_of_durations, output mean_value,
                    input ready);
    modport sink   (input valid, input accepted, input sample_count, input smallest,
                    input largest, input sum_of_durations, input mean_value,
                    output ready);
endinterface

// ===== src/lsa_cfg_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel carrying the discard threshold.
// Depends on lsa_pkg.
interface lsa_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lsa_pkg::DUR_W-1:0]  discard_threshold;

    modport source (output valid, output discard_threshold, input ready);
    modport sink   (input valid, input discard_threshold, output ready);
endinterface

// ===== src/lsa_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for one transaction: capture, entry read, serial divide, commit.
// Depends on lsa_pkg.
module lsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsa_pkg::t_dp_stat i_stat,
    output lsa_pkg::t_dp_cmd  o_cmd
);

    lsa_pkg::t_state             r_state;
    lsa_pkg::t_state             n_state;
    logic [lsa_pkg::STEP_W-1:0]  r_step_cnt;
    logic                        w_last_step;

    assign w_last_step = (r_step_cnt == lsa_pkg::STEP_W'(lsa_pkg::MEAN_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lsa_pkg::S_IDLE;
            r_step_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == lsa_pkg::S_LOAD) begin
                r_step_cnt <= '0;
            end else if (r_state == lsa_pkg::S_DIVIDE) begin
                r_step_cnt <= r_step_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsa_pkg::S_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = lsa_pkg::S_LOAD;
                end
            end
            lsa_pkg::S_LOAD: begin
                // Discarded samples skip the divide
                n_state = i_stat.keep ? lsa_pkg::S_DIVIDE : lsa_pkg::S_COMMIT;
            end
            lsa_pkg::S_DIVIDE: begin
                if (w_last_step) begin
                    n_state = lsa_pkg::S_COMMIT;
                end
            end
            lsa_pkg::S_COMMIT: begin
                if (!i_stat.out_stall) begin
                    n_state = lsa_pkg::S_IDLE;
                end
            end
            default: n_state = lsa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            lsa_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_stat.in_valid;
            end
            lsa_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
            end
            lsa_pkg::S_DIVIDE: begin
                o_cmd.step = 1'b1;
            end
            lsa_pkg::S_COMMIT: begin
                // Hold until the result register is free
                o_cmd.commit = !i_stat.out_stall;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== src/lsa_datapath.sv =====
`timescale 1ns / 1ps
// Statistics table, threshold register, restoring divider and result register.
// Depends on lsa_pkg and the channel interfaces.
module lsa_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsa_pkg::t_dp_cmd  i_cmd,
    output lsa_pkg::t_dp_stat o_stat,
    lsa_in_if.sink            i_in,
    lsa_cfg_if.sink           i_cfg,
    lsa_out_if.source         o_out
);

    logic [lsa_pkg::DUR_W-1:0]   r_thr;

    logic [lsa_pkg::KIND_W-1:0]  r_kind;
    logic [lsa_pkg::DUR_W-1:0]   r_dur;

    logic [lsa_pkg::DUR_W-1:0]   r_min   [lsa_pkg::NUM_KINDS];
    logic [lsa_pkg::DUR_W-1:0]   r_max   [lsa_pkg::NUM_KINDS];
    logic [lsa_pkg::TOTAL_W-1:0] r_total [lsa_pkg::NUM_KINDS];
    logic [lsa_pkg::COUNT_W-1:0] r_count [lsa_pkg::NUM_KINDS];
    logic [lsa_pkg::MEAN_W-1:0]  r_mean  [lsa_pkg::NUM_KINDS];

    logic                        r_acc;
    logic                        r_ge;
    logic [lsa_pkg::MEAN_W-1:0]  r_quo;
    logic [lsa_pkg::DIV_W-1:0]   r_rem;
    logic [lsa_pkg::DIV_W-1:0]   r_div;

    logic                            r_out_valid;
    logic                            r_o_acc;
    logic [lsa_pkg::COUNT_W-1:0]     r_o_count;
    logic [lsa_pkg::DUR_W-1:0]       r_o_min;
    logic [lsa_pkg::DUR_W-1:0]       r_o_max;
    logic [lsa_pkg::TOTAL_W-1:0]     r_o_total;
    logic [lsa_pkg::MEAN_OUT_W-1:0]  r_o_mean;

    logic [lsa_pkg::KIND_IDX_W-1:0]  w_idx;
    logic                            w_kind_ok;
    logic                            w_keep;
    logic [lsa_pkg::DUR_W-1:0]       w_cur_min;
    logic [lsa_pkg::DUR_W-1:0]       w_cur_max;
    logic [lsa_pkg::TOTAL_W-1:0]     w_cur_total;
    logic [lsa_pkg::COUNT_W-1:0]     w_cur_count;
    logic [lsa_pkg::MEAN_W-1:0]      w_cur_mean;
    logic [lsa_pkg::MEAN_W-1:0]      w_v;
    logic [lsa_pkg::REM_W-1:0]       w_rem_sh;
    logic                            w_fit;

    logic [lsa_pkg::DUR_W-1:0]       n_min;
    logic [lsa_pkg::DUR_W-1:0]       n_max;
    logic [lsa_pkg::TOTAL_W-1:0]     n_total;
    logic [lsa_pkg::COUNT_W-1:0]     n_count;
    logic [lsa_pkg::MEAN_W-1:0]      n_mean;

    assign i_cfg.ready = 1'b1;

    // Entry read, one address: the captured kind
    assign w_idx     = lsa_pkg::KIND_IDX_W'(r_kind);
    assign w_kind_ok = (32'(r_kind) < lsa_pkg::NUM_KINDS);

    always_comb begin
        if (w_kind_ok) begin
            w_cur_min   = r_min[w_idx];
            w_cur_max   = r_max[w_idx];
            w_cur_total = r_total[w_idx];
            w_cur_count = r_count[w_idx];
            w_cur_mean  = r_mean[w_idx];
        end else begin
            w_cur_min   = '1;
            w_cur_max   = '0;
            w_cur_total = '0;
            w_cur_count = '0;
            w_cur_mean  = '0;
        end
    end

    assign w_keep = w_kind_ok && (r_dur < r_thr);
    assign w_v    = lsa_pkg::MEAN_W'(r_dur) << lsa_pkg::MEAN_FRAC_BITS;

    assign o_stat.in_valid  = i_in.valid;
    assign o_stat.keep      = w_keep;
    assign o_stat.out_stall = r_out_valid && !o_out.ready;

    // One quotient bit per step
    assign w_rem_sh = {r_rem, r_quo[lsa_pkg::MEAN_W-1]};
    assign w_fit    = (w_rem_sh >= lsa_pkg::REM_W'(r_div));

    always_comb begin
        n_min   = w_cur_min;
        n_max   = w_cur_max;
        n_total = w_cur_total;
        n_count = w_cur_count;
        n_mean  = w_cur_mean;
        if (r_acc) begin
            if (r_dur < w_cur_min) begin
                n_min = r_dur;
            end
            if (r_dur > w_cur_max) begin
                n_max = r_dur;
            end
            n_total = w_cur_total + lsa_pkg::TOTAL_W'(r_dur);
            if (w_cur_count != '1) begin
                n_count = w_cur_count + 1'b1;
            end
            n_mean = r_ge ? (w_cur_mean + r_quo) : (w_cur_mean - r_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= lsa_pkg::RESET_THRESHOLD;
        end else if (i_cfg.valid) begin
            r_thr <= i_cfg.discard_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lsa_pkg::NUM_KINDS; k++) begin
                r_min[k]   <= '1;
                r_max[k]   <= '0;
                r_total[k] <= '0;
                r_count[k] <= '0;
                r_mean[k]  <= '0;
            end
        end else if (i_cmd.commit && r_acc) begin
            r_min[w_idx]   <= n_min;
            r_max[w_idx]   <= n_max;
            r_total[w_idx] <= n_total;
            r_count[w_idx] <= n_count;
            r_mean[w_idx]  <= n_mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_in.event_kind;
            r_dur  <= i_in.duration;
        end
        if (i_cmd.load) begin
            r_acc <= w_keep;
            r_ge  <= (w_v >= w_cur_mean);
            r_quo <= (w_v >= w_cur_mean) ? (w_v - w_cur_mean) : (w_cur_mean - w_v);
            r_rem <= '0;
            r_div <= lsa_pkg::DIV_W'(w_cur_count) + 1'b1;
        end else if (i_cmd.step) begin
            r_rem <= w_fit ? lsa_pkg::DIV_W'(w_rem_sh - lsa_pkg::REM_W'(r_div))
                           : lsa_pkg::DIV_W'(w_rem_sh);
            r_quo <= {r_quo[lsa_pkg::MEAN_W-2:0], w_fit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_acc   <= r_acc;
            r_o_count <= n_count;
            r_o_min   <= n_min;
            r_o_max   <= n_max;
            r_o_total <= n_total;
            r_o_mean  <= lsa_pkg::MEAN_OUT_W'(n_mean);
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.accepted         = r_o_acc;
    assign o_out.sample_count     = r_o_count;
    assign o_out.smallest         = r_o_min;
    assign o_out.largest          = r_o_max;
    assign o_out.sum_of_durations = r_o_total;
    assign o_out.mean_value       = r_o_mean;

endmodule

// ===== src/latency_statistics_accumulator.sv =====
`timescale 1ns / 1ps
// Keeps minimum, maximum, wrapping 64-bit total, saturating count and a running
// Q32.16 mean per event kind; durations at or above the discard threshold are
// reported with accepted low and change nothing. One transaction is in flight
// at a time: a counted sample passes through capture, entry read, 48 steps of
// the one-bit-per-cycle restoring divider for the mean update and commit before
// the next ready; a discarded one skips the divide. The result sits in an
// output register, so the next transaction is taken while it waits. The
// threshold port is always ready and resets to 200000.
// Depends on lsa_pkg, the channel interfaces, lsa_ctrl and lsa_datapath.
module latency_statistics_accumulator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsa_in_if.sink     i_in,
    lsa_cfg_if.sink    i_cfg,
    lsa_out_if.source  o_out
);

    lsa_pkg::t_dp_cmd  w_cmd;
    lsa_pkg::t_dp_stat w_stat;

    assign i_in.ready = w_cmd.in_ready;

    lsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    lsa_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_out   (o_out)
    );

    // One transaction in flight: no acceptance right after another
    a_single_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a transaction is in flight");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |-> (o_out.sample_count != '0))
        else $error("counted sample reported with zero count");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted) |-> (o_out.smallest <= o_out.largest))
        else $error("minimum above maximum after a counted sample");

    a_first_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.accepted && (o_out.sample_count == 32'd1))
        |-> ((o_out.smallest == o_out.largest)
             && (o_out.sum_of_durations == 64'(o_out.smallest))))
        else $error("first sample statistics inconsistent");

endmodule
